[sv/socc_pkg.sv]
// Shared types and constants for the segment/obstacle collision checker.
// No dependencies; imported by socc_cell and the top level.
package socc_pkg;

    // Widths sized for the largest sample count (64) the block supports.
    localparam int CW   = 14;         // raw coordinate width
    localparam int PW   = 22;         // scaled coordinate / difference width
    localparam int SQW  = 2 * PW;     // one squared difference
    localparam int TW   = 16;         // scaled threshold width
    localparam int T2W  = 2 * TW;     // squared threshold width
    localparam int SIW  = 6;          // sample index width
    localparam int OIW  = 4;          // reported obstacle index width

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [1:0] CFG_BODY_RADIUS    = 2'd0;
    localparam logic [1:0] CFG_MARGIN         = 2'd1;
    localparam logic [1:0] CFG_OBSTACLE_COUNT = 2'd2;

    // One sample point travelling down the cell chain.
    typedef struct packed {
        logic                 valid;
        logic signed [PW-1:0] px;
        logic signed [PW-1:0] py;
        logic [SIW-1:0]       sidx;
        logic                 hit;
        logic [OIW-1:0]       hobs;
    } smp_t;

    // Obstacle table write, broadcast to all cells.
    typedef struct packed {
        logic                 en;
        logic [OIW-1:0]       idx;
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
    } load_t;

endpackage

[sv/socc_cell.sv]
// One chain cell: holds one scaled obstacle centre and tests each passing sample.
// Depends on socc_pkg.
module socc_cell
    import socc_pkg::*;
#(
    parameter int IDX     = 0,
    parameter int SAMPLES = 60
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  load_t          load,
    input  logic [4:0]     count,
    input  logic [T2W-1:0] thr2,
    input  smp_t           smp_in,
    output smp_t           smp_out
);

    logic signed [PW-1:0] cx_reg;
    logic signed [PW-1:0] cy_reg;
    smp_t                 s1_reg;
    logic [SQW-1:0]       sqx_reg;
    logic [SQW-1:0]       sqy_reg;
    smp_t                 out_reg;

    logic signed [PW-1:0]  ex;
    logic signed [PW-1:0]  ey;
    logic signed [SQW-1:0] sqx_s;
    logic signed [SQW-1:0] sqy_s;
    logic [SQW-1:0]        sqx_next;
    logic [SQW-1:0]        sqy_next;
    logic [SQW:0]          dist2;
    logic                  in_use;
    logic                  close;
    smp_t                  out_next;

    // Centre stored pre-scaled by the sample count; undefined until loaded.
    always_ff @(posedge clk)
    begin
        if (load.en && (int'(load.idx) == IDX))
        begin
            cx_reg <= PW'(load.x) * PW'(SAMPLES);
            cy_reg <= PW'(load.y) * PW'(SAMPLES);
        end
    end

    always_comb
    begin
        ex       = cx_reg - smp_in.px;
        ey       = cy_reg - smp_in.py;
        // full-width products, never negative
        sqx_s    = ex * ex;
        sqy_s    = ey * ey;
        sqx_next = $unsigned(sqx_s);
        sqy_next = $unsigned(sqy_s);
    end

    always_comb
    begin
        in_use   = IDX < int'(count);
        dist2    = {1'b0, sqx_reg} + {1'b0, sqy_reg};
        close    = dist2 <= (SQW + 1)'(thr2);
        out_next = s1_reg;
        // first hit along the chain wins: lower obstacle index first
        if (!s1_reg.hit && in_use && close)
        begin
            out_next.hit  = 1'b1;
            out_next.hobs = OIW'(IDX);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg  <= '0;
            out_reg <= '0;
        end
        else
        begin
            s1_reg  <= smp_in;
            out_reg <= out_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sqx_reg <= sqx_next;
        sqy_reg <= sqy_next;
    end

    assign smp_out = out_reg;

endmodule

[sv/segment_obstacle_collision_check_unit.sv]
// Top level of the segment/obstacle collision checker: stream ports, config
// registers, sample sequencer and the obstacle cell chain. Depends on socc_pkg, socc_cell.
//
// A load request writes one obstacle centre. A query
// request feeds SAMPLES sample points, one per cycle, into a chain of
// MAX_OBSTACLES cells (two register stages each, one squared-distance test per
// cell); a query's result lands in the output register once the last sample
// has left the chain. New requests are taken only between queries, also
// while a result still waits in the output register. Results report the
// first obstacle, in sample order and then obstacle order, whose centre lies
// within 2*body_radius + margin of a sample; equality counts as blocked.
module segment_obstacle_collision_check_unit
    import socc_pkg::*;
#(
    parameter int SAMPLES       = 60,
    parameter int MAX_OBSTACLES = 16
)
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_tvalid,
    output logic        s_tready,
    // [3:0] obstacle_index, [17:4] obstacle_x, [31:18] obstacle_y,
    // [45:32] start_x, [59:46] start_y, [73:60] end_x, [87:74] end_y
    input  logic [87:0] s_tdata,
    // [0] operation
    input  logic        s_tuser,

    output logic        m_tvalid,
    input  logic        m_tready,
    // [0] blocked, [4:1] blocking_obstacle, [10:5] blocking_sample, [15:11] zero
    output logic [15:0] m_tdata,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_RUN,
        ST_DRAIN,
        ST_DONE
    } state_t;

    state_t               state_reg;
    logic [7:0]           body_radius_reg;
    logic [7:0]           margin_reg;
    logic [4:0]           count_reg;

    logic [TW-1:0]        thr_reg;
    logic [T2W-1:0]       thr2_reg;
    logic signed [PW-1:0] px_reg;
    logic signed [PW-1:0] py_reg;
    logic signed [CW:0]   dx_reg;
    logic signed [CW:0]   dy_reg;
    logic [6:0]           in_cnt_reg;
    logic [6:0]           out_cnt_reg;
    logic                 found_reg;
    logic [OIW-1:0]       res_obs_reg;
    logic [SIW-1:0]       res_smp_reg;
    logic                 m_tvalid_reg;
    logic [15:0]          m_tdata_reg;

    logic                 in_accept;
    logic signed [CW-1:0] sx;
    logic signed [CW-1:0] sy;
    logic signed [CW-1:0] ex;
    logic signed [CW-1:0] ey;
    logic [9:0]           clear_sum;
    load_t                load;
    smp_t                 chain [0:MAX_OBSTACLES];

    assign s_tready  = state_reg == ST_IDLE;
    assign in_accept = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    assign sx = s_tdata[45:32];
    assign sy = s_tdata[59:46];
    assign ex = s_tdata[73:60];
    assign ey = s_tdata[87:74];
    assign clear_sum = {1'b0, body_radius_reg, 1'b0} + {2'b00, margin_reg};

    always_comb
    begin
        load.en  = in_accept && (s_tuser == OP_LOAD);
        load.idx = s_tdata[3:0];
        load.x   = s_tdata[17:4];
        load.y   = s_tdata[31:18];
    end

    always_comb
    begin
        chain[0].valid = state_reg == ST_RUN;
        chain[0].px    = px_reg;
        chain[0].py    = py_reg;
        chain[0].sidx  = in_cnt_reg[SIW-1:0];
        chain[0].hit   = 1'b0;
        chain[0].hobs  = '0;
    end

    genvar j;
    generate
        for (j = 0; j < MAX_OBSTACLES; j++)
        begin : g_cell
            socc_cell #(
                .IDX     (j),
                .SAMPLES (SAMPLES)
            ) u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .load    (load),
                .count   (count_reg),
                .thr2    (thr2_reg),
                .smp_in  (chain[j]),
                .smp_out (chain[j+1])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            body_radius_reg <= 8'd90;
            margin_reg      <= 8'd45;
            count_reg       <= 5'd0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_BODY_RADIUS:    body_radius_reg <= cfg_data;
                CFG_MARGIN:         margin_reg      <= cfg_data;
                CFG_OBSTACLE_COUNT: count_reg       <= cfg_data[4:0];
                default:            ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            in_cnt_reg   <= '0;
            out_cnt_reg  <= '0;
            found_reg    <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            // in ST_DONE the state case below owns m_tvalid_reg
            if (m_tvalid_reg && m_tready && (state_reg != ST_DONE))
            begin
                m_tvalid_reg <= 1'b0;
            end

            // samples leave the chain in order; keep the first one that hit
            if (chain[MAX_OBSTACLES].valid)
            begin
                out_cnt_reg <= out_cnt_reg + 7'd1;
                if (chain[MAX_OBSTACLES].hit && !found_reg)
                begin
                    found_reg <= 1'b1;
                end
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (in_accept && (s_tuser == OP_QUERY))
                    begin
                        found_reg   <= 1'b0;
                        in_cnt_reg  <= '0;
                        out_cnt_reg <= '0;
                        state_reg   <= ST_PREP;
                    end
                end
                ST_PREP:
                begin
                    state_reg <= ST_RUN;
                end
                ST_RUN:
                begin
                    in_cnt_reg <= in_cnt_reg + 7'd1;
                    if (in_cnt_reg == 7'(SAMPLES - 1))
                    begin
                        state_reg <= ST_DRAIN;
                    end
                end
                ST_DRAIN:
                begin
                    if (chain[MAX_OBSTACLES].valid && (out_cnt_reg == 7'(SAMPLES - 1)))
                    begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE:
                begin
                    if (!m_tvalid_reg || m_tready)
                    begin
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // datapath registers, no reset
    always_ff @(posedge clk)
    begin
        if (in_accept && (s_tuser == OP_QUERY))
        begin
            thr_reg <= TW'(clear_sum) * TW'(SAMPLES);
            px_reg  <= PW'(sx) * PW'(SAMPLES);
            py_reg  <= PW'(sy) * PW'(SAMPLES);
            dx_reg  <= (CW + 1)'(ex) - (CW + 1)'(sx);
            dy_reg  <= (CW + 1)'(ey) - (CW + 1)'(sy);
        end

        if (state_reg == ST_PREP)
        begin
            thr2_reg <= T2W'(thr_reg) * T2W'(thr_reg);
        end

        if (state_reg == ST_RUN)
        begin
            px_reg <= px_reg + PW'(dx_reg);
            py_reg <= py_reg + PW'(dy_reg);
        end

        if (chain[MAX_OBSTACLES].valid && chain[MAX_OBSTACLES].hit && !found_reg)
        begin
            res_obs_reg <= chain[MAX_OBSTACLES].hobs;
            res_smp_reg <= chain[MAX_OBSTACLES].sidx;
        end

        if ((state_reg == ST_DONE) && (!m_tvalid_reg || m_tready))
        begin
            m_tdata_reg[0]     <= found_reg;
            m_tdata_reg[4:1]   <= found_reg ? res_obs_reg : '0;
            m_tdata_reg[10:5]  <= found_reg ? res_smp_reg : '0;
            m_tdata_reg[15:11] <= '0;
        end
    end

endmodule
